/* hdl/cmsra_pkg.sv */
// Shared types and hash constants for the count-min sketch row access core.
package cmsra_pkg;

   localparam logic [31:0] MIX_MUL       = 32'h045d_9f3b;
   localparam logic [31:0] JNK_ADD_A     = 32'h7ed5_5d16;
   localparam logic [31:0] JNK_XOR_B     = 32'hc761_c23c;
   localparam logic [31:0] JNK_ADD_C     = 32'h1656_67b1;
   localparam logic [31:0] JNK_ADD_D     = 32'hd3a2_646c;
   localparam logic [31:0] JNK_ADD_E     = 32'hfd70_46c5;
   localparam logic [31:0] JNK_XOR_F     = 32'hb55a_4f09;
   localparam logic [31:0] WNG_XOR       = 32'd61;
   localparam logic [31:0] WNG_MUL       = 32'h27d4_eb2d;
   localparam logic [31:0] MULT_HASH_MUL = 32'd2654435761;

   localparam logic [1:0] ROW_MIX  = 2'd0;
   localparam logic [1:0] ROW_JNK  = 2'd1;
   localparam logic [1:0] ROW_WNG  = 2'd2;
   localparam logic [1:0] ROW_MULT = 2'd3;

   localparam logic MODE_READ = 1'b0;
   localparam logic MODE_INCR = 1'b1;

   typedef struct packed {
      logic       vld;
      logic       mode;
      logic [1:0] row;
   } cmsra_tag_type;

   typedef struct packed {
      logic vld;
      logic mode;
      logic row_ok;
   } cmsra_mtag_type;

endpackage

/* hdl/cmsra_hash.sv */
// Four-stage pipelined row hash of the flow id; the multipliers sit in stages sb and sc.
module cmsra_hash (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  cmsra_pkg::cmsra_tag_type in_tag,
   input  logic [31:0]            in_id,
   output cmsra_pkg::cmsra_tag_type out_tag,
   output logic [31:0]            out_hash
);
   import cmsra_pkg::*;

   cmsra_tag_type s0_tag_ff, sa_tag_ff, sb_tag_ff, sc_tag_ff, sd_tag_ff;
   logic [31:0]   s0_x_ff, sa_x_ff, sb_x_ff, sc_x_ff, sd_x_ff;
   logic [31:0]   sa_x_in, sb_x_in, sc_x_in, sd_x_in;

   logic [31:0] j1, j2, j3, j4, j5, j6;
   logic [31:0] w1, w2, w3;
   logic [31:0] b_mul_k, b_prod, c_pre, c_prod;

   always_comb begin
      j1 = (s0_x_ff + JNK_ADD_A) + (s0_x_ff << 12);
      j2 = (j1 ^ JNK_XOR_B) ^ (j1 >> 19);
      j3 = (j2 + JNK_ADD_C) + (j2 << 5);
      w1 = (s0_x_ff ^ WNG_XOR) ^ (s0_x_ff >> 16);
      w2 = w1 + (w1 << 3);
      w3 = w2 ^ (w2 >> 4);
      case (s0_tag_ff.row)
         ROW_MIX: sa_x_in = (s0_x_ff >> 16) ^ s0_x_ff;
         ROW_JNK: sa_x_in = j3;
         ROW_WNG: sa_x_in = w3;
         default: sa_x_in = s0_x_ff;
      endcase
   end

   always_comb begin
      j4 = (sa_x_ff + JNK_ADD_D) ^ (sa_x_ff << 9);
      j5 = (j4 + JNK_ADD_E) + (j4 << 3);
      j6 = (j5 ^ JNK_XOR_F) ^ (j5 >> 16);
      case (sa_tag_ff.row)
         ROW_MIX: b_mul_k = MIX_MUL;
         ROW_WNG: b_mul_k = WNG_MUL;
         default: b_mul_k = MULT_HASH_MUL;
      endcase
      b_prod  = sa_x_ff * b_mul_k;
      sb_x_in = (sa_tag_ff.row == ROW_JNK) ? j6 : b_prod;
   end

   always_comb begin
      c_pre  = (sb_x_ff >> 16) ^ sb_x_ff;
      c_prod = c_pre * MIX_MUL;
      case (sb_tag_ff.row)
         ROW_MIX: sc_x_in = c_prod;
         ROW_WNG: sc_x_in = sb_x_ff ^ (sb_x_ff >> 15);
         default: sc_x_in = sb_x_ff;
      endcase
   end

   assign sd_x_in = (sc_tag_ff.row == ROW_MIX) ? ((sc_x_ff >> 16) ^ sc_x_ff) : sc_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff.vld <= 1'b0;
         sa_tag_ff.vld <= 1'b0;
         sb_tag_ff.vld <= 1'b0;
         sc_tag_ff.vld <= 1'b0;
         sd_tag_ff.vld <= 1'b0;
      end else if (adv) begin
         s0_tag_ff.vld <= in_tag.vld;
         sa_tag_ff.vld <= s0_tag_ff.vld;
         sb_tag_ff.vld <= sa_tag_ff.vld;
         sc_tag_ff.vld <= sb_tag_ff.vld;
         sd_tag_ff.vld <= sc_tag_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_tag_ff.mode <= in_tag.mode;
         s0_tag_ff.row  <= in_tag.row;
         sa_tag_ff.mode <= s0_tag_ff.mode;
         sa_tag_ff.row  <= s0_tag_ff.row;
         sb_tag_ff.mode <= sa_tag_ff.mode;
         sb_tag_ff.row  <= sa_tag_ff.row;
         sc_tag_ff.mode <= sb_tag_ff.mode;
         sc_tag_ff.row  <= sb_tag_ff.row;
         sd_tag_ff.mode <= sc_tag_ff.mode;
         sd_tag_ff.row  <= sc_tag_ff.row;
         s0_x_ff <= in_id;
         sa_x_ff <= sa_x_in;
         sb_x_ff <= sb_x_in;
         sc_x_ff <= sc_x_in;
         sd_x_ff <= sd_x_in;
      end
   end

   assign out_tag  = sd_tag_ff;
   assign out_hash = sd_x_ff;

endmodule

/* hdl/cmsra_bucket.sv */
// Hash modulo column count by reciprocal multiply, then row-major address.
module cmsra_bucket #(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 1024,
   parameter int AW      = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  cmsra_pkg::cmsra_tag_type in_tag,
   input  logic [31:0]             in_hash,
   output cmsra_pkg::cmsra_mtag_type out_tag,
   output logic [AW-1:0]           out_addr
);
   import cmsra_pkg::*;

   localparam int          BW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int          AXW    = BW + 2;
   localparam logic [63:0] RECIP  = 64'h1_0000_0000 / COLUMNS;
   localparam logic [31:0] COLS_W = 32'(COLUMNS);

   cmsra_tag_type  se_tag_ff, sf_tag_ff, sg_tag_ff;
   cmsra_mtag_type sh_tag_ff, sh_tag_in;
   logic [31:0]    se_h_ff, sf_h_ff, se_q_ff, sf_qc_ff;
   logic [BW-1:0]  sg_bkt_ff, sg_bkt_in;
   logic [AW-1:0]  sh_addr_ff, sh_addr_in;

   logic [63:0]    q_prod;
   logic [31:0]    se_q_in, sf_qc_in, rem, rem_red;
   logic [AXW-1:0] addr_full;

   always_comb begin
      q_prod    = {32'd0, in_hash} * {32'd0, RECIP[31:0]};
      se_q_in   = q_prod[63:32];
      sf_qc_in  = se_q_ff * COLS_W;
      rem       = sf_h_ff - sf_qc_ff;
      rem_red   = (rem >= COLS_W) ? (rem - COLS_W) : rem;
      sg_bkt_in = rem_red[BW-1:0];
      sh_tag_in.vld    = sg_tag_ff.vld;
      sh_tag_in.mode   = sg_tag_ff.mode;
      sh_tag_in.row_ok = (4'(sg_tag_ff.row) < 4'(ROWS));
      addr_full  = AXW'(sg_tag_ff.row) * AXW'(COLUMNS) + AXW'(sg_bkt_ff);
      sh_addr_in = sh_tag_in.row_ok ? AW'(addr_full) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         se_tag_ff.vld <= 1'b0;
         sf_tag_ff.vld <= 1'b0;
         sg_tag_ff.vld <= 1'b0;
         sh_tag_ff.vld <= 1'b0;
      end else if (adv) begin
         se_tag_ff.vld <= in_tag.vld;
         sf_tag_ff.vld <= se_tag_ff.vld;
         sg_tag_ff.vld <= sf_tag_ff.vld;
         sh_tag_ff.vld <= sh_tag_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         se_tag_ff.mode <= in_tag.mode;
         se_tag_ff.row  <= in_tag.row;
         sf_tag_ff.mode <= se_tag_ff.mode;
         sf_tag_ff.row  <= se_tag_ff.row;
         sg_tag_ff.mode <= sf_tag_ff.mode;
         sg_tag_ff.row  <= sf_tag_ff.row;
         sh_tag_ff.mode   <= sh_tag_in.mode;
         sh_tag_ff.row_ok <= sh_tag_in.row_ok;
         se_h_ff    <= in_hash;
         se_q_ff    <= se_q_in;
         sf_h_ff    <= se_h_ff;
         sf_qc_ff   <= sf_qc_in;
         sg_bkt_ff  <= sg_bkt_in;
         sh_addr_ff <= sh_addr_in;
      end
   end

   assign out_tag  = sh_tag_ff;
   assign out_addr = sh_addr_ff;

endmodule

/* hdl/cmsra_counter_mem.sv */
// Counter memory: clearing pass, registered read, increment write-back, forwarding.
module cmsra_counter_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  cmsra_pkg::cmsra_mtag_type in_tag,
   input  logic [AW-1:0]            in_addr,
   output logic                     clearing,
   output cmsra_pkg::cmsra_mtag_type m1_tag,
   output logic [63:0]              m1_count
);
   import cmsra_pkg::*;

   logic [63:0]    mem [DEPTH];

   logic           clr_ff, clr_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   cmsra_mtag_type m1_tag_ff;
   logic [AW-1:0]  m1_addr_ff;
   logic [63:0]    rd_ff;
   logic           fwd_vld_ff;
   logic [AW-1:0]  fwd_addr_ff;
   logic [63:0]    fwd_data_ff;

   logic [63:0]    cur, inc;
   logic           upd_we, we;
   logic [AW-1:0]  wa;
   logic [63:0]    wd;

   always_comb begin
      clr_in      = clr_ff && (clr_addr_ff != AW'(DEPTH - 1));
      clr_addr_in = clr_addr_ff + AW'(1);
      cur    = (fwd_vld_ff && (fwd_addr_ff == m1_addr_ff)) ? fwd_data_ff : rd_ff;
      inc    = cur + 64'd1;
      upd_we = adv && m1_tag_ff.vld && (m1_tag_ff.mode == MODE_INCR) && m1_tag_ff.row_ok;
      we     = clr_ff || upd_we;
      wa     = clr_ff ? clr_addr_ff : m1_addr_ff;
      wd     = clr_ff ? 64'd0 : inc;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (adv) begin
         rd_ff <= mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= 1'b1;
         clr_addr_ff   <= '0;
         m1_tag_ff.vld <= 1'b0;
         fwd_vld_ff    <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         if (adv) begin
            m1_tag_ff.vld <= in_tag.vld;
            fwd_vld_ff    <= upd_we;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_tag_ff.mode   <= in_tag.mode;
         m1_tag_ff.row_ok <= in_tag.row_ok;
         m1_addr_ff       <= in_addr;
         fwd_addr_ff      <= m1_addr_ff;
         fwd_data_ff      <= inc;
      end
   end

   assign clearing = clr_ff;
   assign m1_tag   = m1_tag_ff;
   assign m1_count = m1_tag_ff.row_ok ? cur : 64'd0;

endmodule

/* hdl/count_min_sketch_row_access_core.sv */
// Count-min sketch row access: top level with handshake control and result register.
//
// Request channel (req_): mode, row_select and flow_id move in one transfer when
// req_valid and req_ready are both high. Mode 0 reads the addressed counter, mode 1
// adds one to it (wrapping at 2^64) and returns nothing.
// Response channel (rsp_): one transfer of rsp_count per read; a row at or above
// ROWS reads as zero and its updates are dropped.
// Path: a read's request transfer loads the hash input register, then the read
// passes four hash stages, four modulo and address stages, the memory read and
// the result register before it shows on rsp_valid. One request is taken per
// cycle unless the pipeline is stalled or clearing; an update to the same counter
// in back-to-back cycles is forwarded around the memory's registered read.
// Reset: a clearing pass writes zero to all ROWS*COLUMNS counters, one per cycle;
// req_ready stays low until the pass is done.
// Stall: while a result waits in the output register, the pipeline keeps filling and
// stops only when the next read reaches the memory stage.
module count_min_sketch_row_access_core #(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [1:0]  req_row_select,
   input  logic [31:0] req_flow_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_count
);
   import cmsra_pkg::*;

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmsra_tag_type  in_tag, h_tag;
   cmsra_mtag_type b_tag, m1_tag;
   logic [31:0]    h_hash;
   logic [AW-1:0]  b_addr;
   logic [63:0]    m1_count;
   logic           clearing, adv, m1_read;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_count_ff;

   always_comb begin
      m1_read      = m1_tag.vld && (m1_tag.mode == MODE_READ);
      adv          = !(m1_read && rsp_valid_ff && !rsp_ready);
      req_ready    = adv && !clearing;
      in_tag.vld   = req_valid && req_ready;
      in_tag.mode  = req_mode;
      in_tag.row   = req_row_select;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (adv && m1_read);
   end

   cmsra_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (in_tag),
      .in_id    (req_flow_id),
      .out_tag  (h_tag),
      .out_hash (h_hash)
   );

   cmsra_bucket #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS),
      .AW      (AW)
   ) u_bucket (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (h_tag),
      .in_hash  (h_hash),
      .out_tag  (b_tag),
      .out_addr (b_addr)
   );

   cmsra_counter_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (b_tag),
      .in_addr  (b_addr),
      .clearing (clearing),
      .m1_tag   (m1_tag),
      .m1_count (m1_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && m1_read) begin
         rsp_count_ff <= m1_count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

endmodule

/* test/count_min_sketch_row_access_checker.sv */
// Checker: watches request and response transfers, predicts sketch counters and compares reads.
`timescale 1ns / 100ps

module count_min_sketch_row_access_checker #(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [1:0]  req_row_select,
   input  logic [31:0] req_flow_id,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_count,
   output int          mismatches,
   output int          outstanding,
   output int          compared
);
   import cmsra_pkg::*;

   logic [63:0] sketch_counts [0:ROWS*COLUMNS-1];
   logic [63:0] expected_counts [$];
   int          err_count  = 0;
   int          cmp_count  = 0;
   int          pend_count = 0;

   assign mismatches  = err_count;
   assign compared    = cmp_count;
   assign outstanding = pend_count;

   initial begin
      for (int i = 0; i < ROWS * COLUMNS; i++) sketch_counts[i] = '0;
   end

   function automatic logic [31:0] hash_mix(input logic [31:0] x);
      logic [31:0] v;
      v = ((x >> 16) ^ x) * MIX_MUL;
      v = ((v >> 16) ^ v) * MIX_MUL;
      return (v >> 16) ^ v;
   endfunction

   function automatic logic [31:0] hash_jenkins(input logic [31:0] x);
      logic [31:0] v;
      v = (x + JNK_ADD_A) + (x << 12);
      v = (v ^ JNK_XOR_B) ^ (v >> 19);
      v = (v + JNK_ADD_C) + (v << 5);
      v = (v + JNK_ADD_D) ^ (v << 9);
      v = (v + JNK_ADD_E) + (v << 3);
      v = (v ^ JNK_XOR_F) ^ (v >> 16);
      return v;
   endfunction

   function automatic logic [31:0] hash_wang(input logic [31:0] x);
      logic [31:0] v;
      v = (x ^ WNG_XOR) ^ (x >> 16);
      v = v + (v << 3);
      v = v ^ (v >> 4);
      v = v * WNG_MUL;
      v = v ^ (v >> 15);
      return v;
   endfunction

   function automatic logic [31:0] row_hash(input logic [1:0] row, input logic [31:0] id);
      logic [31:0] h;
      case (row)
         ROW_MIX:  h = hash_mix(id);
         ROW_JNK:  h = hash_jenkins(id);
         ROW_WNG:  h = hash_wang(id);
         ROW_MULT: h = id * MULT_HASH_MUL;
         default:  h = id;
      endcase
      return h;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      err_count++;
   endtask

   // Apply one request to the counter copy; reads queue the count they should return.
   task automatic apply_request(input logic mode, input logic [1:0] row,
                                input logic [31:0] id);
      int unsigned bucket;
      int unsigned slot;
      logic        row_ok;
      bucket = row_hash(row, id) % COLUMNS;
      slot   = row * COLUMNS + bucket;
      row_ok = (row < ROWS);
      if (mode == MODE_INCR) begin
         if (row_ok) sketch_counts[slot] = sketch_counts[slot] + 64'd1;
      end else begin
         expected_counts.push_back(row_ok ? sketch_counts[slot] : 64'd0);
      end
   endtask

   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("response count=%h with no read pending", rsp_count));
            end else begin
               want = expected_counts.pop_front();
               cmp_count++;
               if (rsp_count !== want)
                  report_mismatch($sformatf("count=%h, expected %h", rsp_count, want));
            end
         end
         if (req_valid && req_ready) apply_request(req_mode, req_row_select, req_flow_id);
      end
      pend_count <= expected_counts.size();
   end

endmodule

/* test/count_min_sketch_row_access_core_tb.sv */
// Testbench top: drives sketch read/update requests with random idling and gives the verdict.
`timescale 1ns / 100ps

module count_min_sketch_row_access_core_tb;
   import cmsra_pkg::*;

   localparam int ROWS      = 4;
   localparam int COLUMNS   = 1024;
   localparam int N_RANDOM  = 1600;
   localparam int QUIET_AT  = 1400;
   localparam int PAUSE_AT  = 700;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_mode       = MODE_READ;
   logic [1:0]  req_row_select = ROW_MIX;
   logic [31:0] req_flow_id    = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b1;
   logic [63:0] rsp_count;
   logic        quiet          = 1'b0;

   int          mismatches;
   int          outstanding;
   int          compared;
   int          n_reads   = 0;
   int          n_updates = 0;

   count_min_sketch_row_access_core #(.ROWS(ROWS), .COLUMNS(COLUMNS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_row_select(req_row_select), .req_flow_id(req_flow_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_count(rsp_count)
   );

   count_min_sketch_row_access_checker #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_row_select(req_row_select), .req_flow_id(req_flow_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_count(rsp_count),
      .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #800000;
      $display("Verification failed");
      $finish;
   end

   // Response side back-pressure in bursts.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic mode, input logic [1:0] row,
                               input logic [31:0] id);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_row_select <= row;
      req_flow_id    <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mode == MODE_READ) n_reads++;
      else n_updates++;
   endtask

   task automatic hold_off(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      logic [31:0] hot_ids [0:15];
      logic [31:0] id;
      logic [1:0]  row;
      logic        mode;

      for (int i = 0; i < 16; i++) hot_ids[i] = $urandom;
      hot_ids[0] = 32'h0000_0000;
      hot_ids[1] = 32'hffff_ffff;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: id extremes on every row, back-to-back updates then an immediate read.
      for (int r = 0; r < 4; r++) begin
         send_request(MODE_READ, r[1:0], 32'h0000_0000);
         send_request(MODE_INCR, r[1:0], 32'hffff_ffff);
         send_request(MODE_INCR, r[1:0], 32'hffff_ffff);
         send_request(MODE_READ, r[1:0], 32'hffff_ffff);
      end
      send_request(MODE_INCR, ROW_MULT, 32'h8000_0000);
      send_request(MODE_READ, ROW_MULT, 32'h8000_0000);
      send_request(MODE_INCR, ROW_MIX, 32'h0000_0001);
      send_request(MODE_INCR, ROW_MIX, 32'h0000_0001);
      send_request(MODE_INCR, ROW_MIX, 32'h0000_0001);
      send_request(MODE_READ, ROW_MIX, 32'h0000_0001);
      send_request(MODE_READ, ROW_JNK, 32'h0000_0000);
      send_request(MODE_READ, ROW_WNG, 32'h0000_0001);

      // Random: mostly a small hot set of flows so counters build up and hazards occur.
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == QUIET_AT) quiet <= 1'b1;
         if (i == PAUSE_AT) begin
            hold_off(1);
            while (outstanding != 0) @(posedge clock);
         end
         id   = ($urandom_range(0, 9) < 6) ? hot_ids[$urandom_range(0, 15)] : $urandom;
         row  = 2'($urandom_range(0, 3));
         mode = ($urandom_range(0, 99) < 45) ? MODE_READ : MODE_INCR;
         send_request(mode, row, id);
         if (i < QUIET_AT && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 13));
      end

      hold_off(1);
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("Run covered %0d requests (%0d reads, %0d updates) on all four hash rows,",
               n_reads + n_updates, n_reads, n_updates);
      $display("with %0d read counts compared under random idling on both channels.", compared);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/cmsra_pkg.sv
hdl/cmsra_hash.sv
hdl/cmsra_bucket.sv
hdl/cmsra_counter_mem.sv
hdl/count_min_sketch_row_access_core.sv
test/count_min_sketch_row_access_checker.sv
test/count_min_sketch_row_access_core_tb.sv
